/* rtl/core/gkw_pkg.sv */
// gkw_pkg: shared types, constants and tables of the gaussian kernel weight generator
`timescale 1ns / 1ps
package gkw_pkg;

	localparam int MAX_TAPS_DEFAULT = 64;
	localparam int CNT_W = 7;
	localparam int SIGMA_W = 16;
	localparam int IDX_W = 6;
	localparam int WEIGHT_W = 16;
	localparam int RAW_W = 17;
	localparam int SUM_W = 24;
	localparam int TOTAL_W = 25;
	localparam int REM_W = 48;
	localparam int DEN_W = 32;
	localparam int QUO_W = 21;
	localparam int CMP_W = 53;
	localparam int STEP_W = 5;
	localparam int RECIP_W = 21;
	localparam int RECIP_SH = 20;
	localparam logic [RAW_W-1:0] ONE_Q16 = 17'd65536;
	localparam logic [19:0] EXP_CAP_Q16 = 20'd786432;
	localparam logic [STEP_W-1:0] DIV1_TOP = 5'd20;
	localparam logic [STEP_W-1:0] DIV2_TOP = 5'd16;
	localparam logic [2:0] HORNER_TOP = 3'd7;

	typedef enum logic [3:0] {
		S_IDLE, S_SQ, S_DIV1I, S_DIV1, S_EXPI, S_HMUL, S_HDIV, S_GMUL,
		S_STORE, S_NORM, S_RD, S_DIV2I, S_DIV2, S_EMIT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_SQ, OP_DIV1I, OP_STEP, OP_EXPI, OP_HMUL, OP_HDIV,
		OP_GMUL, OP_STORE, OP_NORM, OP_RD, OP_DIV2I, OP_EMIT
	} op_t;

	typedef struct packed {
		logic req_empty;
		logic last_tap;
		logic step_last;
		logic k_one;
	} status_t;

	function automatic logic [RAW_W-1:0] exp_int(input logic [3:0] n);
		logic [RAW_W-1:0] v;
		case (n)
			4'd0: v = 17'd65536;
			4'd1: v = 17'd24109;
			4'd2: v = 17'd8869;
			4'd3: v = 17'd3263;
			4'd4: v = 17'd1200;
			4'd5: v = 17'd442;
			4'd6: v = 17'd162;
			4'd7: v = 17'd60;
			4'd8: v = 17'd22;
			4'd9: v = 17'd8;
			4'd10: v = 17'd3;
			4'd11: v = 17'd1;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

	// ceil(2^20 / k), exact floor division for 17-bit dividends
	function automatic logic [RECIP_W-1:0] recip(input logic [2:0] k);
		logic [RECIP_W-1:0] v;
		case (k)
			3'd1: v = 21'd1048576;
			3'd2: v = 21'd524288;
			3'd3: v = 21'd349526;
			3'd4: v = 21'd262144;
			3'd5: v = 21'd209716;
			3'd6: v = 21'd174763;
			3'd7: v = 21'd149797;
			default: v = 21'd0;
		endcase
		return v;
	endfunction

endpackage

/* rtl/core/gkw_ram.sv */
// gkw_ram: generic single-port-write, registered-read memory
`timescale 1ns / 1ps
module gkw_ram #(
	parameter int WIDTH = 17,
	parameter int DEPTH = 64
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

/* rtl/core/gkw_ctrl.sv */
// gkw_ctrl: sequencing state machine of the kernel weight generator
`timescale 1ns / 1ps
module gkw_ctrl import gkw_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  status_t status,
	output op_t     op,
	output logic    busy
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (start && !status.req_empty) state_d = S_SQ;
			S_SQ:    state_d = S_DIV1I;
			S_DIV1I: state_d = S_DIV1;
			S_DIV1:  if (status.step_last) state_d = S_EXPI;
			S_EXPI:  state_d = S_HMUL;
			S_HMUL:  state_d = S_HDIV;
			S_HDIV:  state_d = status.k_one ? S_GMUL : S_HMUL;
			S_GMUL:  state_d = S_STORE;
			S_STORE: state_d = status.last_tap ? S_NORM : S_DIV1I;
			S_NORM:  state_d = S_RD;
			S_RD:    state_d = S_DIV2I;
			S_DIV2I: state_d = S_DIV2;
			S_DIV2:  if (status.step_last) state_d = S_EMIT;
			S_EMIT:  state_d = status.last_tap ? S_IDLE : S_RD;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		op = OP_NONE;
		case (state_q)
			S_IDLE:  op = (start && !status.req_empty) ? OP_LOAD : OP_NONE;
			S_SQ:    op = OP_SQ;
			S_DIV1I: op = OP_DIV1I;
			S_DIV1:  op = OP_STEP;
			S_EXPI:  op = OP_EXPI;
			S_HMUL:  op = OP_HMUL;
			S_HDIV:  op = OP_HDIV;
			S_GMUL:  op = OP_GMUL;
			S_STORE: op = OP_STORE;
			S_NORM:  op = OP_NORM;
			S_RD:    op = OP_RD;
			S_DIV2I: op = OP_DIV2I;
			S_DIV2:  op = OP_STEP;
			S_EMIT:  op = OP_EMIT;
			default: op = OP_NONE;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !status.req_empty |=> busy)
		else $error("accepted request did not start");
	a_empty_ignored: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && status.req_empty |=> !busy)
		else $error("empty request started work");
	a_emit_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EMIT && status.last_tap |=> state_q == S_IDLE)
		else $error("final beat did not end request");
endmodule

/* rtl/core/gkw_dp.sv */
// gkw_dp: datapath with tap store, shared divider, exponential unit and sum
`timescale 1ns / 1ps
module gkw_dp import gkw_pkg::*; #(
	parameter int MAX_TAPS = MAX_TAPS_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  op_t                 op,
	input  logic [CNT_W-1:0]    tap_count,
	input  logic [SIGMA_W-1:0]  sigma,
	output status_t             status,
	output logic                valid,
	output logic [IDX_W-1:0]    tap_index,
	output logic [WEIGHT_W-1:0] weight,
	output logic                last
);
	localparam int IW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int CNW = IW + 1;

	logic [CNW-1:0]     count_q;
	logic [IW-1:0]      i_q;
	logic [SIGMA_W-1:0] s_q;
	logic [DEN_W-1:0]   d_q;
	logic [REM_W-1:0]   r_q;
	logic [QUO_W-1:0]   q_q;
	logic [STEP_W-1:0]  j_q;
	logic               cap_q;
	logic [3:0]         n_q;
	logic [15:0]        f_q;
	logic [RAW_W-1:0]   t_q;
	logic [32:0]        prod_q;
	logic [2:0]         k_q;
	logic [RAW_W-1:0]   g_q;
	logic [SUM_W-1:0]   sum_q;
	logic [TOTAL_W-1:0] total_q;
	logic               valid_q;
	logic [IDX_W-1:0]   idx_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic               last_q;

	logic [7:0]         i8;
	logic [15:0]        isq;
	logic [CMP_W-1:0]   dsh;
	logic               fits;
	logic [19:0]        e_val;
	logic [37:0]        hprod;
	logic [RAW_W-1:0]   hq;
	logic [33:0]        gprod;
	logic [RAW_W-1:0]   rdata;
	logic               last_tap;

	assign i8 = 8'(i_q);
	assign isq = i8 * i8;
	assign dsh = CMP_W'(d_q) << j_q;
	assign fits = (CMP_W'(r_q) >= dsh);
	assign e_val = q_q[19:0];
	assign hprod = 38'(prod_q[32:16]) * 38'(recip(k_q));
	assign hq = hprod[RECIP_SH +: RAW_W];
	assign gprod = 34'(exp_int(n_q)) * 34'(t_q) + 34'd32768;
	assign last_tap = ((CNW'(i_q) + CNW'(1)) == count_q);

	assign status.req_empty = (tap_count == '0);
	assign status.last_tap = last_tap;
	assign status.step_last = (j_q == '0);
	assign status.k_one = (k_q == 3'd1);

	gkw_ram #(.WIDTH(RAW_W), .DEPTH(MAX_TAPS)) u_store (
		.clk   (clk),
		.we    (op == OP_STORE),
		.waddr (i_q),
		.wdata (g_q),
		.re    (op == OP_RD),
		.raddr (i_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				count_q <= (32'(tap_count) > 32'(MAX_TAPS)) ? CNW'(MAX_TAPS) : CNW'(tap_count);
				s_q <= (sigma == '0) ? SIGMA_W'(1) : sigma;
				i_q <= '0;
				sum_q <= '0;
			end
			OP_SQ: d_q <= s_q * s_q;
			OP_DIV1I: begin
				r_q <= REM_W'({isq, 31'b0});
				q_q <= '0;
				j_q <= DIV1_TOP;
			end
			OP_STEP: begin
				if (fits) begin
					r_q <= REM_W'(CMP_W'(r_q) - dsh);
				end
				q_q <= {q_q[QUO_W-2:0], fits};
				j_q <= j_q - STEP_W'(1);
			end
			OP_EXPI: begin
				cap_q <= q_q[20] || (e_val >= EXP_CAP_Q16);
				n_q <= e_val[19:16];
				f_q <= e_val[15:0];
				t_q <= ONE_Q16;
				k_q <= HORNER_TOP;
			end
			OP_HMUL: prod_q <= 33'(f_q) * 33'(t_q);
			OP_HDIV: begin
				t_q <= ONE_Q16 - hq;
				k_q <= k_q - 3'd1;
			end
			OP_GMUL: g_q <= cap_q ? '0 : gprod[16 +: RAW_W];
			OP_STORE: begin
				sum_q <= sum_q + SUM_W'(g_q);
				i_q <= i_q + IW'(1);
			end
			OP_NORM: begin
				total_q <= {sum_q, 1'b0} - TOTAL_W'(ONE_Q16);
				i_q <= '0;
			end
			OP_DIV2I: begin
				r_q <= REM_W'({rdata, 16'b0}) + REM_W'(total_q[TOTAL_W-1:1]);
				d_q <= DEN_W'(total_q);
				q_q <= '0;
				j_q <= DIV2_TOP;
			end
			OP_EMIT: begin
				idx_q <= i8[IDX_W-1:0];
				weight_q <= q_q[16] ? '1 : q_q[15:0];
				last_q <= last_tap;
				i_q <= i_q + IW'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= (op == OP_EMIT);
		end
	end

	assign valid = valid_q;
	assign tap_index = idx_q;
	assign weight = weight_q;
	assign last = last_q;

	a_emit_beat: assert property (@(posedge clk) disable iff (!arst_n)
		op == OP_EMIT |=> valid)
		else $error("emit without result beat");
	a_beat_single: assert property (@(posedge clk) disable iff (!arst_n)
		valid |=> !valid)
		else $error("result beat longer than one cycle");
endmodule

/* rtl/core/gaussian_kernel_weights.sv */
// gaussian_kernel_weights: top level of the normalized gaussian kernel weight generator
//
// command channel: tap_count and sigma (unsigned Q8.8) are taken at a rising edge with
// start high and busy low; busy stays high until the request's last beat is out.
// a tap_count of zero is ignored and busy stays low. counts above MAX_TAPS are clipped.
// result channel: one beat per tap, in order of distance, each on tap_index, weight
// (Q0.16, saturated) and last for exactly one cycle while valid is high.
// the receiver cannot hold beats off; no stall path exists.
// work for a request of n taps: sigma is squared, then each tap's raw value is built
// and stored (21-step divide for the exponent, 7 horner steps of a multiply and a
// divide by k each, one rounding multiply, one store), then the sum is normalized
// and each output beat takes a store read, a 17-step divide and an emit.
// the restoring divider is shared by both loops.
// reset (arst_n low) returns the sequencer to idle and drops valid; the tap store
// needs no clearing since every entry is written before it is read.
`timescale 1ns / 1ps
module gaussian_kernel_weights import gkw_pkg::*; #(
	parameter int MAX_TAPS = MAX_TAPS_DEFAULT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [CNT_W-1:0]    tap_count,
	input  logic [SIGMA_W-1:0]  sigma,
	output logic                valid,
	output logic [IDX_W-1:0]    tap_index,
	output logic [WEIGHT_W-1:0] weight,
	output logic                last
);
	op_t     op;
	status_t status;

	gkw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.op     (op),
		.busy   (busy)
	);

	gkw_dp #(.MAX_TAPS(MAX_TAPS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.tap_count (tap_count),
		.sigma     (sigma),
		.status    (status),
		.valid     (valid),
		.tap_index (tap_index),
		.weight    (weight),
		.last      (last)
	);
endmodule
